@@ hdl/swrm_pkg.sv @@
`timescale 1ns / 1ps
package swrm_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_UPDATE,
    ST_MUL,
    ST_DIV,
    ST_SQRT,
    ST_DIGITS,
    ST_DONE
  } swrm_state_t;

  localparam logic [23:0] FULL_SCALE_MV_SQ = 24'd10890000;
  localparam logic [16:0] CODE_MAX_SQ      = 17'd65025;
  localparam logic [11:0] RMS_MAX          = 12'd3300;
  localparam logic [10:0] WINDOW_RESET     = 11'd1000;
  localparam logic [15:0] INTERVAL_RESET   = 16'd120;
  localparam logic        ADDR_WINDOW      = 1'b0;
  localparam logic        ADDR_INTERVAL    = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic update;
    logic mul;
    logic div_start;
    logic div_step;
    logic sqrt_start;
    logic sqrt_step;
    logic digit_step;
    logic finish;
  } swrm_cmd_t;

  typedef struct packed {
    logic div_last;
    logic sqrt_last;
    logic digit_last;
  } swrm_status_t;

endpackage

@@ hdl/swrm_ram.sv @@
`timescale 1ns / 1ps
module swrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/swrm_ctrl.sv @@
`timescale 1ns / 1ps
module swrm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output swrm_pkg::swrm_cmd_t   cmd,
  input  swrm_pkg::swrm_status_t stat
);
  import swrm_pkg::*;

  swrm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_RDWAIT;
        end
      end
      ST_RDWAIT: state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_last) begin
          state_nxt = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        cmd.digit_step = 1'b1;
        if (stat.digit_last) begin
          cmd.finish = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_ready) |=> state_r == ST_DONE)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == ST_RDWAIT)
    else $error("accepted item not started");
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while result pending");
endmodule

@@ hdl/swrm_datapath.sv @@
`timescale 1ns / 1ps
module swrm_datapath #(
  parameter int WINDOW_MAX = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             in_sample,
  input  logic                   cfg_we,
  input  logic                   cfg_sel,
  input  logic [31:0]            cfg_wdata,
  output logic [31:0]            cfg_rdata,
  input  swrm_pkg::swrm_cmd_t    cmd,
  output swrm_pkg::swrm_status_t stat,
  output logic [11:0]            rms_mv,
  output logic [15:0]            digits,
  output logic                   updated,
  output logic                   is_zero
);
  import swrm_pkg::*;

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam logic [CW-1:0] WMAX = CW'(WINDOW_MAX);

  logic [10:0] window_r;
  logic [15:0] interval_r;
  logic [AW-1:0] ptr_r;
  logic [CW-1:0] count_r;
  logic [26:0] sum_r;
  logic [15:0] latch_r;
  logic [15:0] shown_r;
  logic [7:0] sample_r;
  logic [CW-1:0] w_eff;
  logic [AW-1:0] p_eff, p_inc;
  logic [7:0] old_q;
  logic full;

  // Divider: num = 10890000*sum (52 bits), den = count*65025.
  logic [51:0] quo_r;
  logic [32:0] rem_r;
  logic [31:0] den_r;
  logic [5:0] cnt_r;
  logic [32:0] rem_sh, rem_sub;
  // Square root on the low 32 bits of the quotient.
  logic [31:0] sv_r, root_r, bit_r;
  logic [11:0] rms_r;
  logic [11:0] dval_r;
  logic [1:0] dig_r;
  logic [15:0] acc_r;
  logic upd_r;
  logic [26:0] sum_tmp;

  always_comb begin
    if (window_r == 11'd0) begin
      w_eff = CW'(1);
    end else if ({21'd0, window_r} > 32'(WINDOW_MAX)) begin
      w_eff = WMAX;
    end else begin
      w_eff = CW'(window_r);
    end
    p_eff = ({1'b0, ptr_r} >= (AW+1)'(w_eff)) ? '0 : ptr_r;
    p_inc = ((AW+1)'(p_eff) + 1'b1 >= (AW+1)'(w_eff)) ? '0 : AW'(p_eff + 1'b1);
    full = count_r >= w_eff;
  end

  swrm_ram #(.WIDTH(8), .DEPTH(WINDOW_MAX)) u_ring (
    .clk  (clk),
    .we   (cmd.update),
    .waddr(p_eff),
    .wdata(sample_r),
    .raddr(p_eff),
    .rdata(old_q)
  );

  assign sum_tmp = (full ? sum_r - 27'(old_q * old_q) : sum_r) + 27'(sample_r * sample_r);
  assign rem_sh = {rem_r[31:0], quo_r[51]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      interval_r <= INTERVAL_RESET;
      ptr_r <= '0;
      count_r <= '0;
      sum_r <= '0;
      latch_r <= '0;
      shown_r <= '0;
      upd_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_sel == ADDR_WINDOW) begin
        window_r <= cfg_wdata[10:0];
        ptr_r <= '0;
        count_r <= '0;
        sum_r <= '0;
      end
      if (cfg_we && cfg_sel == ADDR_INTERVAL) begin
        interval_r <= cfg_wdata[15:0];
      end
      if (cmd.update) begin
        ptr_r <= p_inc;
        if (!full) begin
          count_r <= count_r + 1'b1;
        end
        sum_r <= sum_tmp;
      end
      // The ones digit is what remains in dval_r on the last digit step.
      if (cmd.finish) begin
        upd_r <= 1'b0;
        if (latch_r != 16'hFFFF) begin
          if (latch_r + 16'd1 >= interval_r) begin
            latch_r <= '0;
            shown_r <= {acc_r[15:4], dval_r[3:0]};
            upd_r <= 1'b1;
          end else begin
            latch_r <= latch_r + 16'd1;
          end
        end else if (latch_r >= interval_r) begin
          latch_r <= '0;
          shown_r <= {acc_r[15:4], dval_r[3:0]};
          upd_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
    end
    if (cmd.mul) begin
      quo_r <= 52'(sum_r) * 52'(FULL_SCALE_MV_SQ);
      den_r <= 32'(count_r) * 32'(CODE_MAX_SQ);
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
      if (!rem_sub[32]) begin
        rem_r <= rem_sub;
        quo_r <= {quo_r[50:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[50:0], 1'b0};
      end
      if (stat.div_last) begin
        sv_r <= rem_sub[32] ? {quo_r[30:0], 1'b0} : {quo_r[30:0], 1'b1};
        root_r <= '0;
        bit_r <= 32'h4000_0000;
      end
    end
    if (cmd.sqrt_step) begin
      if (bit_r != 32'd0) begin
        if (sv_r >= root_r + bit_r) begin
          sv_r <= sv_r - (root_r + bit_r);
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      if (stat.sqrt_last) begin
        rms_r <= (root_r > 32'(RMS_MAX)) ? RMS_MAX : root_r[11:0];
        dval_r <= (root_r > 32'(RMS_MAX)) ? RMS_MAX : root_r[11:0];
        dig_r <= '0;
        acc_r <= '0;
      end
    end
    // Extract digits by repeated subtraction of the place value, one per cycle.
    if (cmd.digit_step) begin
      case (dig_r)
        2'd0: if (dval_r >= 12'd1000) begin
          dval_r <= dval_r - 12'd1000; acc_r[15:12] <= acc_r[15:12] + 4'd1;
        end else dig_r <= 2'd1;
        2'd1: if (dval_r >= 12'd100) begin
          dval_r <= dval_r - 12'd100; acc_r[11:8] <= acc_r[11:8] + 4'd1;
        end else dig_r <= 2'd2;
        2'd2: if (dval_r >= 12'd10) begin
          dval_r <= dval_r - 12'd10; acc_r[7:4] <= acc_r[7:4] + 4'd1;
        end else dig_r <= 2'd3;
        default: acc_r[3:0] <= dval_r[3:0];
      endcase
    end
  end

  // The sqrt stage is told to run exactly 16 bit positions.
  logic [4:0] sq_cnt_r;
  always_ff @(posedge clk) begin
    if (cmd.div_step) sq_cnt_r <= '0;
    else if (cmd.sqrt_step) sq_cnt_r <= sq_cnt_r + 1'b1;
  end

  assign stat.div_last = cnt_r == 6'd51;
  assign stat.sqrt_last = sq_cnt_r == 5'd16;
  assign stat.digit_last = dig_r == 2'd3;
  assign rms_mv = rms_r;
  assign digits = shown_r;
  assign updated = upd_r;
  assign is_zero = sample_r == 8'd0;
  assign cfg_rdata = cfg_sel ? {16'd0, interval_r} : {21'd0, window_r};
endmodule

@@ hdl/sliding_window_rms_meter.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Handshake              | Payload
// in_      | input     | in_valid / in_ready    | in_sample
// out_     | output    | out_valid / out_ready  | out_rms_millivolts, out_digit_*, flags
// cfg_     | APB       | psel, penable, pwrite  | window_size @0, update_interval @4
// Each item passes through the accept cycle, a ring read wait, the update, one
// multiply, a 52-step restoring divide, an iterative square root, the digit
// steps set by the digit values, and the result cycle.
// Reset is synchronous; the sample ring needs no clearing pass.
// A stalled result holds the block until it is taken.
module sliding_window_rms_meter #(
  parameter int WINDOW_MAX = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_rms_millivolts,
  output logic [3:0]  out_digit_thousands,
  output logic [3:0]  out_digit_hundreds,
  output logic [3:0]  out_digit_tens,
  output logic [3:0]  out_digit_ones,
  output logic        out_display_updated,
  output logic        out_sample_is_zero,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import swrm_pkg::*;

  swrm_cmd_t cmd;
  swrm_status_t stat;
  logic [15:0] digits;

  assign cfg_pready = 1'b1;

  swrm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  swrm_datapath #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_sample(in_sample),
    .cfg_we(cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00
            && cfg_paddr[2] == 1'b0 || cfg_psel && cfg_penable && cfg_pwrite
            && cfg_paddr == 3'd4),
    .cfg_sel(cfg_paddr[2]), .cfg_wdata(cfg_pwdata), .cfg_rdata(cfg_prdata),
    .cmd(cmd), .stat(stat), .rms_mv(out_rms_millivolts), .digits(digits),
    .updated(out_display_updated), .is_zero(out_sample_is_zero)
  );

  assign out_digit_thousands = digits[15:12];
  assign out_digit_hundreds = digits[11:8];
  assign out_digit_tens = digits[7:4];
  assign out_digit_ones = digits[3:0];
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import swrm_pkg::*;

  localparam int WIN_MAX       = 1024;
  localparam int IDLE_LIMIT    = 200000;
  localparam logic [2:0] REG_WINDOW   = 3'd0;
  localparam logic [2:0] REG_INTERVAL = 3'd4;

  typedef struct {
    logic [11:0] rms;
    logic [3:0]  d_th;
    logic [3:0]  d_hu;
    logic [3:0]  d_te;
    logic [3:0]  d_on;
    logic        updated;
    logic        is_zero;
  } meter_reading_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_sample;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] out_rms_millivolts;
  logic [3:0]  out_digit_thousands;
  logic [3:0]  out_digit_hundreds;
  logic [3:0]  out_digit_tens;
  logic [3:0]  out_digit_ones;
  logic        out_display_updated;
  logic        out_sample_is_zero;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sliding_window_rms_meter u_top (.*);

  // Predictor state.
  logic [7:0]  ring_copy [WIN_MAX];
  int unsigned ring_wr;
  int unsigned held_count;
  logic [26:0] sq_sum;
  int unsigned since_latch;
  logic [15:0] digits_shown;
  logic [10:0] window_reg;
  logic [15:0] interval_reg;

  logic [7:0]     samples_pending [$];
  meter_reading_t readings_expected [$];
  int   mismatches;
  int   idle_cycles;
  bit   hold_sender;
  bit   long_stall_req;
  int   burst_left;
  int   gap_left;
  int   stall_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [11:0] isqrt32(logic [31:0] v);
    logic [31:0] root;
    logic [31:0] bitv;
    root = 0;
    bitv = 32'h4000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[11:0];
  endfunction

  function automatic meter_reading_t predict_reading(logic [7:0] s);
    meter_reading_t r;
    int unsigned w;
    int unsigned p;
    logic [63:0] num;
    logic [63:0] den;
    logic [31:0] rms;
    w = window_reg;
    if (w < 1) w = 1;
    if (w > WIN_MAX) w = WIN_MAX;
    p = ring_wr;
    if (p >= w) p = 0;
    if (held_count >= w) sq_sum = sq_sum - ring_copy[p] * ring_copy[p];
    else held_count++;
    ring_copy[p] = s;
    p++;
    if (p >= w) p = 0;
    ring_wr = p;
    sq_sum = sq_sum + s * s;
    num = 64'(FULL_SCALE_MV_SQ) * 64'(sq_sum);
    den = 64'(held_count) * 64'(CODE_MAX_SQ);
    rms = isqrt32(32'(num / den));
    if (rms > 3300) rms = 3300;
    r.updated = 1'b0;
    if (since_latch < 16'hFFFF) since_latch++;
    if (since_latch >= interval_reg) begin
      digits_shown = {4'((rms / 1000) % 10), 4'((rms / 100) % 10),
                      4'((rms / 10) % 10), 4'(rms % 10)};
      since_latch = 0;
      r.updated = 1'b1;
    end
    r.rms = rms[11:0];
    r.d_th = digits_shown[15:12];
    r.d_hu = digits_shown[11:8];
    r.d_te = digits_shown[7:4];
    r.d_on = digits_shown[3:0];
    r.is_zero = (s == 0);
    return r;
  endfunction

  // Sender: bursts and gaps, fed from the pending queue.
  // An accepted item has already left the queue when the next one is picked.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        readings_expected.push_back(predict_reading(in_sample));
        void'(samples_pending.pop_front());
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (hold_sender || samples_pending.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_sample <= samples_pending[0];
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 200);
          end
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (long_stall_req && stall_left == 0) begin
      stall_left <= 3000;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    meter_reading_t e;
    if (rst_n && out_valid && out_ready) begin
      if (readings_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result rms=%0d", out_rms_millivolts);
      end else begin
        e = readings_expected.pop_front();
        if (out_rms_millivolts !== e.rms || out_digit_thousands !== e.d_th ||
            out_digit_hundreds !== e.d_hu || out_digit_tens !== e.d_te ||
            out_digit_ones !== e.d_on || out_display_updated !== e.updated ||
            out_sample_is_zero !== e.is_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch exp rms=%0d dig=%0d%0d%0d%0d upd=%0b zero=%0b, ",
                      "got rms=%0d dig=%0d%0d%0d%0d upd=%0b zero=%0b"},
                     e.rms, e.d_th, e.d_hu, e.d_te, e.d_on, e.updated, e.is_zero,
                     out_rms_millivolts, out_digit_thousands, out_digit_hundreds,
                     out_digit_tens, out_digit_ones, out_display_updated,
                     out_sample_is_zero);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == REG_WINDOW) begin
      window_reg = data[10:0];
      ring_wr = 0;
      held_count = 0;
      sq_sum = 0;
    end else begin
      interval_reg = data[15:0];
    end
  endtask

  task automatic drain();
    while (samples_pending.size() != 0 || in_valid || readings_expected.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic queue_random(int n, int zero_pct);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 99) < zero_pct ? 0 : $urandom_range(1, 4))
        0: samples_pending.push_back(8'd0);
        1: samples_pending.push_back(8'd255);
        2: samples_pending.push_back(8'($urandom_range(200, 255)));
        default: samples_pending.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    int win_sizes [8] = '{1, 2, 3, 7, 16, 1024, 0, 2047};
    int intervals [8] = '{1, 0, 3, 5, 65535, 2, 17, 1};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = 8'd0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = 3'd0;
    cfg_pwdata = 32'd0;
    hold_sender = 1'b0;
    long_stall_req = 1'b0;
    mismatches = 0;
    ring_wr = 0;
    held_count = 0;
    sq_sum = 0;
    since_latch = 0;
    digits_shown = 0;
    window_reg = WINDOW_RESET;
    interval_reg = INTERVAL_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings with extremes and single-bit codes.
    samples_pending.push_back(8'd0);
    samples_pending.push_back(8'd255);
    samples_pending.push_back(8'd255);
    for (int b = 0; b < 8; b++) samples_pending.push_back(8'(1 << b));
    samples_pending.push_back(8'd0);
    drain();
    // Small window with interval zero: wrap-around and latch every sample.
    write_reg(REG_WINDOW, 32'd2);
    write_reg(REG_INTERVAL, 32'd0);
    for (int i = 0; i < 6; i++) samples_pending.push_back(i[0] ? 8'd255 : 8'd1);
    drain();
    // Interval raised so the count runs, then lowered below it: latches on the next sample.
    write_reg(REG_INTERVAL, 32'd50);
    samples_pending.push_back(8'd128);
    samples_pending.push_back(8'd127);
    drain();
    write_reg(REG_INTERVAL, 32'd1);
    samples_pending.push_back(8'd200);
    drain();

    // Random phases through several settings; the full window wraps once.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_WINDOW, win_sizes[ph]);
      write_reg(REG_INTERVAL, intervals[ph]);
      if (ph == 3) begin
        // Hold the receiver while the sender keeps offering items.
        long_stall_req = 1'b1;
        queue_random(40, 10);
        wait (stall_left > 0);
        long_stall_req = 1'b0;
        drain();
      end
      queue_random((ph == 5) ? 1050 : 30, 8);
      drain();
    end
    // Sender held while new items are queued, then released for one more burst.
    hold_sender = 1'b1;
    queue_random(30, 5);
    repeat (50) @(posedge clk);
    hold_sender = 1'b0;
    drain();
    write_reg(REG_WINDOW, 32'd1000);
    write_reg(REG_INTERVAL, 32'd120);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
